// ===== src/zero_one_shortest_path_assert.svh =====
// Assertion macros used by zero_one_shortest_path.sv.
`ifndef ZERO_ONE_SHORTEST_PATH_ASSERT_SVH
`define ZERO_ONE_SHORTEST_PATH_ASSERT_SVH
`ifndef SYNTHESIS
`define ZOSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ZOSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ZOSP_ASSERT_IMPL(label, ante, cons)
`define ZOSP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/zosp_pkg.sv =====
`timescale 1ns / 1ps
package zosp_pkg;
  localparam int MaxNodes = 128;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int AdjDepth = MaxNodes * MaxNodes;
  localparam int AdjAw = $clog2(AdjDepth);
  localparam int CostW = NodeW + 1;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_RUN = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  // Adjacency encoding: 1 = edge weight 0, 2 = edge weight 1, 0 = no edge,
  // so that a cleared memory (all zero) means no edges.
  localparam logic [1:0] ADJ_NONE = 2'd0;
  localparam logic [1:0] ADJ_W0 = 2'd1;
  localparam logic [1:0] ADJ_W1 = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] from_node;
    logic [7:0] to_node;
    logic edge_weight;
  } zosp_in_t;
endpackage

// ===== src/zosp_if.sv =====
`timescale 1ns / 1ps
interface zosp_in_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [7:0] from_node;
  logic [7:0] to_node;
  logic edge_weight;
  modport source (output valid, command, from_node, to_node, edge_weight, input ready);
  modport sink (input valid, command, from_node, to_node, edge_weight, output ready);
endinterface

interface zosp_out_if;
  logic valid;
  logic ready;
  logic signed [7:0] distance;
  modport source (output valid, distance, input ready);
  modport sink (input valid, distance, output ready);
endinterface

// ===== src/zosp_ram.sv =====
`timescale 1ns / 1ps
module zosp_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/zero_one_shortest_path.sv =====
`timescale 1ns / 1ps
// zero_one_shortest_path: 0/1-weight shortest path over a stored graph.
// Input channel (in_*): command 0 adds edge from_node->to_node with
// edge_weight (smaller weight kept), 1 runs a query, 2 clears the graph,
// 3 does nothing. Output channel (out_*): one distance per query, -1 when
// the target is unreachable or the source or target is out of range.
// Configuration (cfg_*): node_count, source_node, target_node, written
// while the block is idle.
// Add edge does a read, modify, write of the adjacency memory.
// Clear sweeps all 16384 entries with the input held off, one entry per cycle.
// A query alternates scan passes, which pick the cheapest reached unsettled
// node, and relax passes over its edges: each scan or relax pass issues n
// reads and then drains the registered memory read.
// After reset all 16384 adjacency memory entries are swept clear with
// in_ready low. The result sits in an output register; while the receiver
// stalls it holds and no new transaction is accepted.
module zero_one_shortest_path (
  input  logic clk,
  input  logic rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  zosp_in_if.sink    in_ch,
  zosp_out_if.source out_ch
);
  import zosp_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_ADD_RD = 4'd2;
  localparam logic [3:0] ST_ADD_WR = 4'd3;
  localparam logic [3:0] ST_INIT = 4'd4;
  localparam logic [3:0] ST_SCAN = 4'd5;
  localparam logic [3:0] ST_RELAX = 4'd6;
  localparam logic [3:0] ST_RES = 4'd7;
  localparam logic [3:0] ST_OUT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [7:0] ncount_r, src_r, tgt_r;
  logic [AdjAw-1:0] cnt_r, cnt_nxt;
  logic [NodeW:0] idx_r, idx_nxt;
  logic [NodeW-1:0] u_r, u_nxt;
  logic found_r, found_nxt;
  logic [CostW-1:0] min_r, min_nxt, ucost_r, ucost_nxt;
  logic [MaxNodes-1:0] settled_r, settled_nxt, reached_r, reached_nxt;
  logic [AdjAw-1:0] eaddr_r, eaddr_nxt;
  logic ew_r, ew_nxt;
  logic signed [7:0] dist_r, dist_nxt;
  logic out_v_r, out_v_nxt;

  logic [8:0] n_w;
  logic [NodeW:0] n_lim;

  // Adjacency memory.
  logic adj_we;
  logic [AdjAw-1:0] adj_wa, adj_ra;
  logic [1:0] adj_wd, adj_rd;
  // Cost memory.
  logic cost_we;
  logic [NodeW-1:0] cost_wa, cost_ra;
  logic [CostW-1:0] cost_wd, cost_rd;

  zosp_ram #(.Width(2), .Depth(AdjDepth)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .raddr(adj_ra), .rdata(adj_rd));
  zosp_ram #(.Width(CostW), .Depth(MaxNodes)) u_cost (
    .clk(clk), .we(cost_we), .waddr(cost_wa), .wdata(cost_wd),
    .raddr(cost_ra), .rdata(cost_rd));

  assign n_w = (ncount_r > 8'(MaxNodes)) ? 9'(MaxNodes) : {1'b0, ncount_r};
  assign n_lim = (NodeW + 1)'(n_w);

  logic in_range_a, in_range_b, q_ok;
  assign in_range_a = (in_ch.from_node != 8'd0) && ({1'b0, in_ch.from_node} <= n_w);
  assign in_range_b = (in_ch.to_node != 8'd0) && ({1'b0, in_ch.to_node} <= n_w);
  assign q_ok = (src_r != 8'd0) && ({1'b0, src_r} <= n_w) &&
                (tgt_r != 8'd0) && ({1'b0, tgt_r} <= n_w);

  assign in_ch.ready = (state_r == ST_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.distance = dist_r;

  // Scan/relax pipelines: the index issued in one cycle returns data next cycle.
  logic [NodeW-1:0] pidx_r;
  logic pv_r;
  logic [NodeW-1:0] idx_lo;
  assign idx_lo = idx_r[NodeW-1:0];

  logic [CostW-1:0] cand;
  assign cand = ucost_r + CostW'(adj_rd == ADJ_W1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    u_nxt = u_r;
    found_nxt = found_r;
    min_nxt = min_r;
    ucost_nxt = ucost_r;
    settled_nxt = settled_r;
    reached_nxt = reached_r;
    eaddr_nxt = eaddr_r;
    ew_nxt = ew_r;
    dist_nxt = dist_r;
    out_v_nxt = out_v_r;
    adj_we = 1'b0;
    adj_wa = eaddr_r;
    adj_wd = ADJ_NONE;
    adj_ra = eaddr_r;
    cost_we = 1'b0;
    cost_wa = pidx_r;
    cost_wd = cand;
    cost_ra = idx_lo;
    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        adj_we = 1'b1;
        adj_wa = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AdjAw'(AdjDepth - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          case (in_ch.command)
            CMD_ADD: begin
              if (in_range_a && in_range_b) begin
                eaddr_nxt = {in_ch.from_node[NodeW-1:0] - 1'b1,
                             in_ch.to_node[NodeW-1:0] - 1'b1};
                ew_nxt = in_ch.edge_weight;
                state_nxt = ST_ADD_RD;
              end
            end
            CMD_RUN: begin
              if (q_ok) begin
                settled_nxt = '0;
                reached_nxt = '0;
                reached_nxt[src_r[NodeW-1:0] - 1'b1] = 1'b1;
                state_nxt = ST_INIT;
              end else begin
                dist_nxt = -8'sd1;
                out_v_nxt = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: begin
        // Keep the smaller weight: weight 0 always wins, weight 1 only over none.
        adj_we = (ew_r == 1'b0) || (adj_rd == ADJ_NONE);
        adj_wd = ew_r ? ADJ_W1 : ADJ_W0;
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        cost_we = 1'b1;
        cost_wa = src_r[NodeW-1:0] - 1'b1;
        cost_wd = '0;
        idx_nxt = '0;
        found_nxt = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // Issue reads for idx_r, compare the data of the previous index.
        if (pv_r && reached_r[pidx_r] && !settled_r[pidx_r] &&
            (!found_r || cost_rd < min_r)) begin
          found_nxt = 1'b1;
          min_nxt = cost_rd;
          u_nxt = pidx_r;
        end
        if (idx_r == n_lim) begin
          if (!pv_r) begin
            if (!found_r) begin
              state_nxt = ST_RES;
              idx_nxt = '0;
            end else begin
              settled_nxt[u_r] = 1'b1;
              ucost_nxt = min_r;
              idx_nxt = '0;
              state_nxt = ST_RELAX;
            end
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RELAX: begin
        adj_ra = {u_r, idx_lo};
        if (pv_r && adj_rd != ADJ_NONE && !settled_r[pidx_r] &&
            (!reached_r[pidx_r] || cand < cost_rd)) begin
          cost_we = 1'b1;
          reached_nxt[pidx_r] = 1'b1;
        end
        if (idx_r == n_lim) begin
          if (!pv_r) begin
            idx_nxt = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_RES: begin
        cost_ra = tgt_r[NodeW-1:0] - 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!reached_r[tgt_r[NodeW-1:0] - 1'b1]) begin
          dist_nxt = -8'sd1;
        end else if (cost_rd > CostW'(127)) begin
          dist_nxt = 8'sd127;
        end else begin
          dist_nxt = 8'(cost_rd);
        end
        out_v_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Relax reads cost of idx in the same cycle as adjacency, so that both
  // arrive together; a write to the entry just read cannot collide because
  // each index is visited once per pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
      out_v_r <= 1'b0;
      ncount_r <= 8'd1;
      src_r <= 8'd1;
      tgt_r <= 8'd1;
      pv_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_v_r <= out_v_nxt;
      idx_r <= idx_nxt;
      pv_r <= (state_r == ST_SCAN || state_r == ST_RELAX) && (idx_r != n_lim);
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_COUNT: ncount_r <= cfg_wdata;
          REG_SOURCE: src_r <= cfg_wdata;
          REG_TARGET: tgt_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= idx_lo;
    u_r <= u_nxt;
    found_r <= found_nxt;
    min_r <= min_nxt;
    ucost_r <= ucost_nxt;
    settled_r <= settled_nxt;
    reached_r <= reached_nxt;
    eaddr_r <= eaddr_nxt;
    ew_r <= ew_nxt;
    dist_r <= dist_nxt;
  end

`include "zero_one_shortest_path_assert.svh"
  `ZOSP_ASSERT_IMPL(a_no_accept_busy, state_r != ST_IDLE, !in_ch.ready)
  `ZOSP_ASSERT_NEXT(a_out_holds, out_v_r && !out_ch.ready, out_v_r && $stable(dist_r))
  `ZOSP_ASSERT_NEXT(a_out_after_res, state_r == ST_OUT, out_v_r)
  `ZOSP_ASSERT_IMPL(a_no_write_idle, state_r == ST_IDLE, !adj_we && !cost_we)
endmodule
